/* hdl/rpd_pkg.sv */
// Shared types, constants and operation codes for the PPM frame decoder.
package rpd_pkg;

  // Default sizing of the decoder
  localparam int MAX_CHANNELS_DEF  = 8;
  localparam int FILTER_WINDOW_DEF = 4;

  // Field and datapath widths
  localparam int WIDTH_W = 16;
  localparam int TS_W    = 32;
  localparam int CHAN_W  = 8;
  localparam int ALU_W   = 32;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register map
  localparam logic [PADDR_W-1:0] ADDR_MAX_PULSE  = 3'd0;
  localparam logic [WIDTH_W-1:0] MAX_PULSE_RESET = 16'd2500;

  // Item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Shared unit operations
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  // Request to the shared add/subtract unit
  typedef struct packed {
    logic             op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

/* hdl/rpd_alu.sv */
// Shared add/subtract unit with carry/borrow out.
module rpd_alu import rpd_pkg::*; (
  input  alu_req_t         req,
  output logic [ALU_W-1:0] y,
  output logic             c
);

  // Add or subtract; c is carry on add, borrow on subtract
  always_comb begin
    if (req.op == ALU_SUB) begin
      {c, y} = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      {c, y} = {1'b0, req.a} + {1'b0, req.b};
    end
  end

endmodule

/* hdl/rpd_frame_mem.sv */
// Frame store memory: one write port, one registered read port.
module rpd_frame_mem import rpd_pkg::*; #(
  parameter int ADDR_W = 5
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [WIDTH_W-1:0] wdata,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [WIDTH_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH_W-1:0] mem [DEPTH];

  // Write one entry and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/rc_ppm_frame_decoder_top.sv */
// Top level: PPM edge decoding, frame ring and averaged channel read-out.
//
// Input channel: an item is taken when start is high and busy is low.
// in_kind = 0 is a rising edge at in_timestamp (microseconds, wraps at 2^32);
// in_kind = 1 reads channel in_channel averaged over FILTER_WINDOW frames.
// Result channel: out_valid strobes for one cycle with out_average_width;
// only reads produce a beat, and the receiver cannot stall it.
// Steps per item, which share the add/subtract unit and the frame memory:
//   pulse edge: subtract, compare, back to idle;
//   sync edge:  subtract, compare, then copy the N channels collected (one copy per cycle);
//   read:       FILTER_WINDOW frame fetches and adds, then a divide step
//               (reciprocal multiply), result strobes the cycle after;
//               an out-of-range channel answers 0 the cycle after acceptance.
// Reset: registers return to defaults (max_pulse_width = 2500) and a clearing
// pass zeroes all frame memory entries (32 by default), one entry a cycle,
// with busy high. Configuration through the APB port is taken at any time,
// including during the clearing pass.
module rc_ppm_frame_decoder_top import rpd_pkg::*; #(
  parameter int MAX_CHANNELS  = MAX_CHANNELS_DEF,
  parameter int FILTER_WINDOW = FILTER_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [TS_W-1:0]    in_timestamp,
  input  logic [CHAN_W-1:0]  in_channel,
  // result channel
  output logic               out_valid,
  output logic [WIDTH_W-1:0] out_average_width,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
  localparam int SLOT_W  = (FILTER_WINDOW > 1) ? $clog2(FILTER_WINDOW) : 1;
  localparam int ADDR_W  = SLOT_W + CH_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int SUM_W   = WIDTH_W + $clog2(FILTER_WINDOW);
  // floor(sum / FILTER_WINDOW) == (sum * RECIP) >> DIV_SH for every sum below 2^SUM_W
  localparam int DIV_SH  = SUM_W + $clog2(FILTER_WINDOW);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int RECIP   = ((1 << DIV_SH) + FILTER_WINDOW - 1) / FILTER_WINDOW;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ESUB  = 3'd2;
  localparam logic [2:0] S_ECMP  = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;
  localparam logic [2:0] S_RRD   = 3'd5;
  localparam logic [2:0] S_RACC  = 3'd6;
  localparam logic [2:0] S_DIV   = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [WIDTH_W-1:0] max_r, max_nxt;
  logic [TS_W-1:0]    prev_r, prev_nxt;
  logic [TS_W-1:0]    ts_r, ts_nxt;
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [SLOT_W-1:0]  f_r, f_nxt;
  logic [CH_W-1:0]    idx_r, idx_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [ALU_W-1:0]   acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WIDTH_W-1:0] out_data_r, out_data_nxt;

  logic [WIDTH_W-1:0] stage_r [MAX_CHANNELS];
  logic               stage_we;

  alu_req_t           alu_req;
  logic [ALU_W-1:0]   alu_y;
  logic               alu_c;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [WIDTH_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [WIDTH_W-1:0] mem_rdata;

  logic               cfg_wr;
  logic [SLOT_W-1:0]  slot_adv;
  logic [CNT_W-1:0]   idx_inc;
  logic [PROD_W-1:0]  div_prod;

  rpd_alu u_alu (
    .req (alu_req),
    .y   (alu_y),
    .c   (alu_c)
  );

  rpd_frame_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_MAX_PULSE);
  assign prdata = (paddr == ADDR_MAX_PULSE) ? {{(PDATA_W-WIDTH_W){1'b0}}, max_r} : '0;
  assign max_nxt = cfg_wr ? pwdata[WIDTH_W-1:0] : max_r;

  // Handshake and result ports
  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_average_width = out_data_r;

  // Helpers for ring advance, copy end and the constant divide
  assign slot_adv  = (slot_r == SLOT_W'(FILTER_WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
  assign idx_inc   = CNT_W'(idx_r) + CNT_W'(1);
  assign div_prod  = PROD_W'(acc_r[SUM_W-1:0]) * PROD_W'(RECIP);
  assign mem_raddr = {f_r, ch_r};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    ts_nxt        = ts_r;
    ch_nxt        = ch_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    f_nxt         = f_r;
    idx_nxt       = idx_r;
    clr_nxt       = clr_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    stage_we      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = {slot_r, idx_r};
    mem_wdata     = stage_r[idx_r];
    alu_req.op    = ALU_SUB;
    alu_req.a     = ts_r;
    alu_req.b     = prev_r;
    case (state_r)
      S_CLEAR: begin
        // zero one frame entry per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ts_nxt  = in_timestamp;
          ch_nxt  = in_channel[CH_W-1:0];
          acc_nxt = '0;
          f_nxt   = '0;
          if (in_kind == KIND_EDGE) begin
            state_nxt = S_ESUB;
          end else if (in_channel >= CHAN_W'(MAX_CHANNELS)) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
          end else begin
            state_nxt = S_RRD;
          end
        end
      end
      S_ESUB: begin
        // interval since the previous edge, modulo 2^32
        alu_req.op = ALU_SUB;
        alu_req.a  = ts_r;
        alu_req.b  = prev_r;
        acc_nxt    = alu_y;
        prev_nxt   = ts_r;
        state_nxt  = S_ECMP;
      end
      S_ECMP: begin
        // borrow means interval above max_pulse_width: sync gap
        alu_req.op = ALU_SUB;
        alu_req.a  = {{(ALU_W-WIDTH_W){1'b0}}, max_r};
        alu_req.b  = acc_r;
        if (!alu_c) begin
          if (cnt_r < CNT_W'(MAX_CHANNELS)) begin
            stage_we = 1'b1;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end else if (cnt_r == '0) begin
          slot_nxt  = slot_adv;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        // copy staged widths into the current slot
        mem_we  = 1'b1;
        idx_nxt = idx_r + CH_W'(1);
        if (idx_inc == cnt_r) begin
          cnt_nxt   = '0;
          slot_nxt  = slot_adv;
          state_nxt = S_IDLE;
        end
      end
      S_RRD: begin
        state_nxt = S_RACC;
      end
      S_RACC: begin
        // accumulate one frame's width
        alu_req.op = ALU_ADD;
        alu_req.a  = acc_r;
        alu_req.b  = {{(ALU_W-WIDTH_W){1'b0}}, mem_rdata};
        acc_nxt    = alu_y;
        if (f_r == SLOT_W'(FILTER_WINDOW - 1)) begin
          state_nxt = S_DIV;
        end else begin
          f_nxt     = f_r + SLOT_W'(1);
          state_nxt = S_RRD;
        end
      end
      S_DIV: begin
        // divide the sum by FILTER_WINDOW with a reciprocal multiply
        out_valid_nxt = 1'b1;
        out_data_nxt  = div_prod[DIV_SH +: WIDTH_W];
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      max_r       <= MAX_PULSE_RESET;
      prev_r      <= '0;
      cnt_r       <= '0;
      slot_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_r       <= max_nxt;
      prev_r      <= prev_nxt;
      cnt_r       <= cnt_nxt;
      slot_r      <= slot_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ts_r       <= ts_nxt;
    ch_r       <= ch_nxt;
    f_r        <= f_nxt;
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // Staging widths
  always_ff @(posedge clk) begin
    if (stage_we) begin
      stage_r[cnt_r[CH_W-1:0]] <= acc_r[WIDTH_W-1:0];
    end
  end

  // Checks
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_DIV || $past(state_r) == S_IDLE))
    else $error("result strobe outside divide end or out-of-range read");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CHANNELS))
    else $error("channel count past capacity");

  a_copy_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (CNT_W'(idx_r) < cnt_r))
    else $error("copy index beyond collected channels");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_EDGE) |=> (state_r == S_ESUB))
    else $error("edge beat not started");

endmodule
